// File: src/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// shared types, constants and the segment table of the decimal scan unit
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam int VALUE_W     = 32;
    localparam int MAX_DIGITS  = 8;
    localparam int POS_W       = 3;
    localparam int BITS_PER_STEP = 4;
    localparam int STEP_COUNT  = VALUE_W / BITS_PER_STEP;
    localparam logic [POS_W-1:0] STEP_LAST = POS_W'(STEP_COUNT - 1);

    localparam logic [7:0] SELECT_RIGHT_BASE = 8'h80;
    localparam logic [7:0] SELECT_LEFT_BASE  = 8'h01;

    typedef logic [MAX_DIGITS-1:0][3:0] digit_vec_t;

    typedef struct packed {
        logic       left;
        digit_vec_t digits;
    } entry_t;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'b11000000;
            4'd1:    s = 8'b11111001;
            4'd2:    s = 8'b10100100;
            4'd3:    s = 8'b10110000;
            4'd4:    s = 8'b10011001;
            4'd5:    s = 8'b10010010;
            4'd6:    s = 8'b10000010;
            4'd7:    s = 8'b11111000;
            4'd8:    s = 8'b10000000;
            4'd9:    s = 8'b10010000;
            default: s = 8'b11111111;
        endcase
        return s;
    endfunction

endpackage

// File: src/dss_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_in_if / dss_out_if
// valid/ready channels for input transactions and digit results
// ----------------------------------------------------------------------------
interface dss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        justify_left;

    modport source (output valid, output value, output justify_left, input ready);
    modport sink   (input valid, input value, input justify_left, output ready);
endinterface

interface dss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digit_select;
    logic [7:0] segment_pattern;
    logic       last;

    modport source (output valid, output digit_select, output segment_pattern,
                    output last, input ready);
    modport sink   (input valid, input digit_select, input segment_pattern,
                    input last, output ready);
endinterface

// File: src/decimal_seven_segment_scan_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_seven_segment_scan_unit
// decimal digit scan for a multiplexed seven-segment display
//
// channel  dir  fields                                    transaction
// item     in   value[31:0], justify_left                 one number to show
// result   out  digit_select[7:0], segment_pattern[7:0],   one shown digit
//               last
//
// the converter takes 4 value bits per cycle; at its last step it waits while the queue is full
// unless the result is stalled, the scanner gives one result per cycle, up to DIGIT_COUNT per transaction
// a two-entry queue lets conversion of the next transaction overlap the scan
// a value of zero modulo 10^DIGIT_COUNT gives no result
// reset clears control state only; a stalled result holds in its register
// ----------------------------------------------------------------------------
module decimal_seven_segment_scan_unit #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    dss_in_if.sink    item,
    dss_out_if.source result
);
    import dss_pkg::*;

    logic   push;
    entry_t push_entry;
    logic   full;
    logic   pop;
    entry_t pop_entry;
    logic   empty;

    dss_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    dss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    dss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty),
        .result     (result)
    );

endmodule

// File: src/dss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_front
// accepts transactions and converts the value to decimal digits, four bits
// of the binary value per cycle (shift and add-3), waiting at the last step while the queue is full
// ----------------------------------------------------------------------------
module dss_front #(
    parameter int DIGIT_COUNT = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    dss_in_if.sink         item,
    output logic           push,
    output dss_pkg::entry_t push_entry,
    input  logic           full
);
    import dss_pkg::*;

    localparam int BCD_W  = DIGIT_COUNT * 4;
    localparam int WORK_W = BCD_W + VALUE_W;

    logic                busy_reg, busy_next;
    logic [POS_W-1:0]    step_reg, step_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                left_reg, left_next;
    logic [WORK_W-1:0]   work;
    logic                advance;
    logic                take;

    always_comb
    begin
        work = {bcd_reg, bin_reg};
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            for (int k = 0; k < DIGIT_COUNT; k++)
            begin
                if (work[VALUE_W + 4*k +: 4] >= 4'd5)
                begin
                    work[VALUE_W + 4*k +: 4] = work[VALUE_W + 4*k +: 4] + 4'd3;
                end
            end
            work = work << 1;
        end
    end

    assign push    = busy_reg && (step_reg == STEP_LAST) && !full;
    assign advance = busy_reg && ((step_reg != STEP_LAST) || !full);
    assign item.ready = !busy_reg || push;
    assign take    = item.valid && item.ready;

    always_comb
    begin
        push_entry.left   = left_reg;
        push_entry.digits = '0;
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            push_entry.digits[k] = work[VALUE_W + 4*k +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        left_next = left_reg;
        if (take)
        begin
            busy_next = 1'b1;
            step_next = '0;
            bin_next  = item.value;
            bcd_next  = '0;
            left_next = item.justify_left;
        end
        else if (advance)
        begin
            busy_next = !push;
            step_next = step_reg + 1'b1;
            bin_next  = work[VALUE_W-1:0];
            bcd_next  = work[WORK_W-1:VALUE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        left_reg <= left_next;
    end

endmodule

// File: src/dss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_queue
// two-entry queue of converted digit sets between front and back
// ----------------------------------------------------------------------------
module dss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dss_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output dss_pkg::entry_t pop_entry,
    output logic            empty
);
    import dss_pkg::*;

    entry_t      mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: src/dss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_back
// scans a digit set from the first significant digit down to the units
// digit and drives one registered result per cycle while the result is not stalled
// ----------------------------------------------------------------------------
module dss_back (
    input  logic            clk,
    input  logic            rst_n,
    output logic            pop,
    input  dss_pkg::entry_t pop_entry,
    input  logic            empty,
    dss_out_if.source       result
);
    import dss_pkg::*;

    logic             act_reg, act_next;
    digit_vec_t       digits_reg, digits_next;
    logic             left_reg, left_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] placed_reg, placed_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       sel_reg, sel_next;
    logic [7:0]       seg_reg, seg_next;
    logic             last_reg, last_next;

    logic             emit;
    logic             slot_free;
    logic             found;
    logic [POS_W-1:0] first_pos;
    logic [3:0]       cur_digit;

    always_comb
    begin
        found     = 1'b0;
        first_pos = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (pop_entry.digits[i] != 4'd0)
            begin
                found     = 1'b1;
                first_pos = POS_W'(i);
            end
        end
    end

    assign cur_digit = digits_reg[pos_reg];
    assign emit      = act_reg && (!out_valid_reg || result.ready);
    assign slot_free = !act_reg || (emit && (pos_reg == '0));
    assign pop       = slot_free && !empty;

    always_comb
    begin
        act_next    = act_reg;
        digits_next = digits_reg;
        left_next   = left_reg;
        pos_next    = pos_reg;
        placed_next = placed_reg;
        if (emit)
        begin
            pos_next    = pos_reg - 1'b1;
            placed_next = placed_reg + 1'b1;
            if (pos_reg == '0)
            begin
                act_next = 1'b0;
            end
        end
        if (pop)
        begin
            act_next    = found;
            digits_next = pop_entry.digits;
            left_next   = pop_entry.left;
            pos_next    = first_pos;
            placed_next = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        sel_next       = sel_reg;
        seg_next       = seg_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            sel_next       = left_reg ? (SELECT_LEFT_BASE << placed_reg)
                                      : (SELECT_RIGHT_BASE >> pos_reg);
            seg_next       = seg_code(cur_digit);
            last_next      = (pos_reg == '0);
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.digit_select    = sel_reg;
    assign result.segment_pattern = seg_reg;
    assign result.last            = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        left_reg   <= left_next;
        pos_reg    <= pos_next;
        placed_reg <= placed_next;
        sel_reg    <= sel_next;
        seg_reg    <= seg_next;
        last_reg   <= last_next;
    end

endmodule

// File: src/dss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_checker
// port-level checks of the decimal scan unit
// ----------------------------------------------------------------------------
module dss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] digit_select,
    input logic [7:0] segment_pattern,
    input logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_select)
            && $stable(segment_pattern) && $stable(last))
        else $error("result changed while stalled");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot(digit_select))
        else $error("digit select not one-hot");

    a_dot_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> segment_pattern[7])
        else $error("decimal point driven");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind decimal_seven_segment_scan_unit dss_checker u_dss_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .digit_select    (result.digit_select),
    .segment_pattern (result.segment_pattern),
    .last            (result.last)
);
